FILE: design/hsrt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsrt_pkg
// Shared constants, command codes and control types for the handle/slot
// remap table.
// ---------------------------------------------------------------------------
package hsrt_pkg;

   localparam int HANDLES      = 256;
   localparam int IDX_W        = $clog2(HANDLES);
   localparam int HANDLE_W     = 8;
   localparam int SLOT_IN_W    = 8;
   localparam int SLOT_W       = 9;
   localparam int HANDLE_LIMIT = (HANDLES < 256) ? HANDLES : 256;
   localparam int CNT_W        = $clog2(HANDLE_LIMIT + 1);

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_ALLOC  = 3'd1,
      OP_LOOKUP = 3'd2,
      OP_DELETE = 3'd3,
      OP_MOVE   = 3'd4,
      OP_ADD    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // latch item fields, restart sweep index
      logic clear;
      logic alloc;
      logic add;
      logic lookup_rd;
      logic sweep_rd;
      logic rsp_imm;    // result computed from the item itself
      logic rsp_look;   // result from the lookup read
      logic rsp_done;   // all-zero result after a sweep
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic idx_last;
   } sts_type;

endpackage

FILE: design/hsrt_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsrt_ctrl
// Command sequencer: decodes each item and steps the datapath through
// the direct table updates, the lookup read or the full-table renumber sweep.
// ---------------------------------------------------------------------------
module hsrt_ctrl
   import hsrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   req_cmd,
   input  sts_type      sts,
   output logic         busy,
   output ctl_type      ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.accept = 1'b1;
               unique case (op_type'(req_cmd)) inside
                  OP_CLEAR: begin
                     ctl.clear   = 1'b1;
                     ctl.rsp_imm = 1'b1;
                  end
                  OP_ALLOC: begin
                     ctl.alloc   = 1'b1;
                     ctl.rsp_imm = 1'b1;
                  end
                  OP_LOOKUP: begin
                     ctl.lookup_rd = 1'b1;
                     state_in      = ST_LOOK;
                  end
                  OP_DELETE, OP_MOVE: begin
                     state_in = ST_SWEEP;
                  end
                  OP_ADD: begin
                     ctl.add     = 1'b1;
                     ctl.rsp_imm = 1'b1;
                  end
                  default: begin
                     ctl.rsp_imm = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            ctl.rsp_look = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            ctl.sweep_rd = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last entry is written back in this cycle
            ctl.rsp_done = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/hsrt_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsrt_dpath
// Table storage, presence flags, handle counter, sweep read/modify/write
// pipeline and result registers.
// ---------------------------------------------------------------------------
module hsrt_dpath
   import hsrt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_type                  ctl,
   input  logic [2:0]               req_cmd,
   input  logic [HANDLE_W-1:0]      req_handle,
   input  logic [SLOT_IN_W-1:0]     req_slot_id,
   input  logic [SLOT_IN_W-1:0]     req_to_slot,
   output sts_type                  sts,
   output logic                     rsp_valid,
   output logic [HANDLE_W-1:0]      rsp_new_handle,
   output logic signed [SLOT_W-1:0] rsp_slot,
   output logic                     rsp_found,
   output logic                     rsp_full_res
);

   logic signed [SLOT_W-1:0] mem [HANDLES];

   logic [HANDLES-1:0]       present_ff;
   logic [CNT_W-1:0]         next_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic                     is_move_ff;
   logic [SLOT_IN_W-1:0]     from_ff;
   logic [SLOT_IN_W-1:0]     to_ff;

   logic signed [SLOT_W-1:0] rd_data_ff;
   logic                     wb_ff;
   logic [IDX_W-1:0]         wb_addr_ff;
   logic                     look_hit_ff;

   logic                     rsp_valid_ff;
   logic [HANDLE_W-1:0]      rsp_new_handle_ff;
   logic signed [SLOT_W-1:0] rsp_slot_ff;
   logic                     rsp_found_ff;
   logic                     rsp_full_ff;

   logic                     full;
   logic                     in_range;
   logic [IDX_W-1:0]         req_idx;
   logic [IDX_W-1:0]         alloc_idx;
   logic [IDX_W-1:0]         rd_addr;
   logic                     rd_en;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [SLOT_W-1:0] wr_data;
   logic signed [SLOT_W-1:0] from_s;
   logic signed [SLOT_W-1:0] to_s;
   logic signed [SLOT_W-1:0] wb_data;

   assign full      = next_ff >= CNT_W'(HANDLE_LIMIT);
   assign in_range  = 32'(req_handle) < HANDLES;
   assign req_idx   = IDX_W'(req_handle);
   assign alloc_idx = IDX_W'(next_ff);
   assign sts.idx_last = idx_ff == IDX_W'(HANDLES - 1);

   assign rd_en   = ctl.lookup_rd | ctl.sweep_rd;
   assign rd_addr = ctl.lookup_rd ? req_idx : idx_ff;

   // renumber one entry; -1 never matches since slots are non-negative
   assign from_s = $signed({1'b0, from_ff});
   assign to_s   = $signed({1'b0, to_ff});

   always_comb begin
      wb_data = rd_data_ff;
      if (!is_move_ff) begin
         if (rd_data_ff == from_s) begin
            wb_data = -SLOT_W'(1);
         end else if (rd_data_ff > from_s) begin
            wb_data = rd_data_ff - SLOT_W'(1);
         end
      end else begin
         if (rd_data_ff == from_s) begin
            wb_data = to_s;
         end else if (from_s < to_s && rd_data_ff > from_s && rd_data_ff <= to_s) begin
            wb_data = rd_data_ff - SLOT_W'(1);
         end else if (from_s > to_s && rd_data_ff < from_s && rd_data_ff >= to_s) begin
            wb_data = rd_data_ff + SLOT_W'(1);
         end
      end
   end

   // single write port: the sweep write-back never overlaps an item update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wb_addr_ff;
      wr_data = wb_data;
      if (wb_ff) begin
         wr_en = present_ff[wb_addr_ff];
      end else if (ctl.alloc && !full) begin
         wr_en   = 1'b1;
         wr_addr = alloc_idx;
         wr_data = $signed({1'b0, req_slot_id});
      end else if (ctl.add && in_range) begin
         wr_en   = 1'b1;
         wr_addr = req_idx;
         wr_data = $signed({1'b0, req_slot_id});
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         next_ff    <= CNT_W'(1);
      end else if (ctl.clear) begin
         present_ff <= '0;
         next_ff    <= CNT_W'(1);
      end else if (ctl.alloc && !full) begin
         present_ff[alloc_idx] <= 1'b1;
         next_ff               <= next_ff + CNT_W'(1);
      end else if (ctl.add && in_range) begin
         present_ff[req_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff  <= 1'b0;
         idx_ff <= '0;
      end else begin
         wb_ff <= ctl.sweep_rd;
         if (ctl.accept) begin
            idx_ff <= '0;
         end else if (ctl.sweep_rd) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= idx_ff;
      if (ctl.accept) begin
         is_move_ff <= op_type'(req_cmd) == OP_MOVE;
         from_ff    <= req_slot_id;
         to_ff      <= req_to_slot;
      end
      if (ctl.lookup_rd) begin
         look_hit_ff <= in_range && present_ff[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.rsp_imm | ctl.rsp_look | ctl.rsp_done;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_imm) begin
         rsp_new_handle_ff <= (ctl.alloc && !full) ? HANDLE_W'(next_ff) : '0;
         rsp_full_ff       <= ctl.alloc && full;
         rsp_slot_ff       <= '0;
         rsp_found_ff      <= 1'b0;
      end else if (ctl.rsp_look) begin
         rsp_new_handle_ff <= '0;
         rsp_full_ff       <= 1'b0;
         rsp_slot_ff       <= look_hit_ff ? rd_data_ff : -SLOT_W'(1);
         rsp_found_ff      <= look_hit_ff;
      end else if (ctl.rsp_done) begin
         rsp_new_handle_ff <= '0;
         rsp_full_ff       <= 1'b0;
         rsp_slot_ff       <= '0;
         rsp_found_ff      <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_handle = rsp_new_handle_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_full_res   = rsp_full_ff;

endmodule

FILE: design/handle_slot_remap_table_core.sv
`timescale 1ns / 1ps
// Clear, allocate, add custom, unused codes: result in the cycle after accept, busy stays low.
// Lookup: registered table read, then the result register; busy while in the lookup state.
// Delete and move: sweep of all HANDLES entries, one table entry read and rewritten per cycle,
// the read running one entry ahead of the write-back, then the drain state; busy throughout.
// Reset: presence flags cleared and handle counter set to 1 at once; no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
// handle_slot_remap_table_core
// Handle to slot remap table: top level joining sequencer and datapath.
// ---------------------------------------------------------------------------
module handle_slot_remap_table_core
   import hsrt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_cmd,
   input  logic [HANDLE_W-1:0]      req_handle,
   input  logic [SLOT_IN_W-1:0]     req_slot_id,
   input  logic [SLOT_IN_W-1:0]     req_to_slot,
   output logic                     rsp_valid,
   output logic [HANDLE_W-1:0]      rsp_new_handle,
   output logic signed [SLOT_W-1:0] rsp_slot,
   output logic                     rsp_found,
   output logic                     rsp_full_res
);

   ctl_type ctl;
   sts_type sts;

   hsrt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .sts     (sts),
      .busy    (busy),
      .ctl     (ctl)
   );

   hsrt_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_cmd        (req_cmd),
      .req_handle     (req_handle),
      .req_slot_id    (req_slot_id),
      .req_to_slot    (req_to_slot),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_new_handle (rsp_new_handle),
      .rsp_slot       (rsp_slot),
      .rsp_found      (rsp_found),
      .rsp_full_res   (rsp_full_res)
   );

   a_imm_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == OP_CLEAR || req_cmd == OP_ALLOC || req_cmd == OP_ADD))
      |=> (rsp_valid && !busy))
      else $error("single-cycle item gave no result");

   a_lookup_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == OP_LOOKUP) |=> (busy && !rsp_valid) ##1 rsp_valid)
      else $error("lookup result timing wrong");

   a_full_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_full_res) |-> (rsp_new_handle == '0 && !rsp_found))
      else $error("full allocate issued a handle");

   a_found_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found && rsp_slot != '0) |-> (rsp_slot == -SLOT_W'(1)))
      else $error("miss result carries a slot");

endmodule
